// ===== rtl/ldlt_pkg.sv =====
// Package for the lazy deletion list table: sizes, codes, types shared by
// the interfaces, the cell row and the controller.
// Depends on nothing.
package ldlt_pkg;

	localparam int CAPACITY    = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int SUM_W       = CNT_W + 1;
	localparam int OP_W        = 2;
	localparam int DATA_W      = 32;
	localparam int POS_W       = 6;
	localparam int COUNT_W     = 7;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_REMOVE = 2'd1,
		OP_READ   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL      = 3'd2,
		ST_EMPTY     = 3'd3,
		ST_BEYOND    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_READ,
		S_COMPACT,
		S_RESULT
	} state_t;

	typedef struct packed {
		value_t value;
		logic   mark;
	} entry_t;

	typedef struct packed {
		logic   write;
		logic   seed;
		logic   search;
		logic   load;
		logic   shift;
		logic   swap;
		logic   phase;
		logic   clear;
		value_t data;
		cnt_t   length;
	} cell_cmd_t;

	typedef struct packed {
		logic   hit;
		value_t head_value;
		logic   head_mark;
	} chain_stat_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] read_value;
		logic              read_marked;
		logic              compacted;
	} result_t;

	function automatic value_t ext_value(input logic [DATA_W-1:0] v);
		value_t r;
		for (int b = 0; b < VALUE_WIDTH; b++) begin
			r[b] = v[(b < DATA_W) ? b : DATA_W - 1];
		end
		return r;
	endfunction

	function automatic logic [DATA_W-1:0] read_field(input value_t e);
		logic [DATA_W-1:0] r;
		for (int b = 0; b < DATA_W; b++) begin
			r[b] = (b < VALUE_WIDTH) ? e[(b < VALUE_WIDTH) ? b : 0] : 1'b0;
		end
		return r;
	endfunction

	function automatic logic pos_beyond(input logic [POS_W-1:0] pos, input cnt_t length);
		return 32'(pos) >= 32'(length);
	endfunction

endpackage

// ===== rtl/ldlt_if.sv =====
// Request and response channel interfaces of the lazy deletion list table.
// Depends on ldlt_pkg.
interface ldlt_req_if import ldlt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, output operation, output value, output position,
		input ready);
	modport sink (input valid, input operation, input value, input position,
		output ready);
endinterface

interface ldlt_rsp_if import ldlt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	status_t                  status;
	logic signed [DATA_W-1:0] read_value;
	logic                     read_marked;
	logic [COUNT_W-1:0]       live_count;
	logic [COUNT_W-1:0]       deleted_count;
	logic                     compacted;

	modport source (output valid, output status, output read_value, output read_marked,
		output live_count, output deleted_count, output compacted, input ready);
	modport sink (input valid, input status, input read_value, input read_marked,
		input live_count, input deleted_count, input compacted, output ready);
endinterface

// ===== rtl/lazy_delete_list_table.sv =====
// Lazy deletion list table: append, mark-on-remove and read over a row of cells.
// A remove may also compact the row.
// Throughput: one transaction at a time; the next may enter while a result waits.
// Reset arst_n clears counts, marks and control state at once; no clearing pass.
module lazy_delete_list_table import ldlt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ldlt_req_if.sink   req,
	ldlt_rsp_if.source rsp
);

	cell_cmd_t           cmd;
	chain_stat_t         stat;
	entry_t              ent     [CAPACITY];
	entry_t              carry   [CAPACITY];
	logic                live    [CAPACITY];
	logic                hole    [CAPACITY];
	logic                tok     [CAPACITY];
	entry_t              r_ent   [CAPACITY];
	entry_t              r_carry [CAPACITY];
	logic                r_live  [CAPACITY];
	logic                l_hole  [CAPACITY];
	logic                l_tok   [CAPACITY];
	logic [CAPACITY-1:0] hit_vec;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		if (g == CAPACITY - 1) begin : g_last
			assign r_ent[g]   = '0;
			assign r_carry[g] = '0;
			assign r_live[g]  = 1'b0;
		end else begin : g_mid
			assign r_ent[g]   = ent[g+1];
			assign r_carry[g] = carry[g+1];
			assign r_live[g]  = live[g+1];
		end
		if (g == 0) begin : g_first
			assign l_hole[g] = 1'b0;
			assign l_tok[g]  = cmd.seed;
		end else begin : g_rest
			assign l_hole[g] = hole[g-1];
			assign l_tok[g]  = tok[g-1];
		end

		ldlt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (idx_t'(g)),
			.cmd        (cmd),
			.right_entry(r_ent[g]),
			.right_live (r_live[g]),
			.right_carry(r_carry[g]),
			.left_hole  (l_hole[g]),
			.left_tok   (l_tok[g]),
			.entry      (ent[g]),
			.live       (live[g]),
			.hole       (hole[g]),
			.carry      (carry[g]),
			.tok        (tok[g]),
			.hit        (hit_vec[g])
		);
	end

	assign stat.hit        = |hit_vec;
	assign stat.head_value = carry[0].value;
	assign stat.head_mark  = carry[0].mark;

	ldlt_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cmd   (cmd),
		.stat  (stat)
	);

endmodule

// ===== rtl/ldlt_cell.sv =====
// One cell of the list row: holds one entry, its deletion mark, a search
// token and a read carry, and trades them with its neighbors.
// Depends on ldlt_pkg.
module ldlt_cell import ldlt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  idx_t      idx,
	input  cell_cmd_t cmd,
	input  entry_t    right_entry,
	input  logic      right_live,
	input  entry_t    right_carry,
	input  logic      left_hole,
	input  logic      left_tok,
	output entry_t    entry,
	output logic      live,
	output logic      hole,
	output entry_t    carry,
	output logic      tok,
	output logic      hit
);

	value_t value_q;
	logic   mark_q;
	entry_t carry_q;
	logic   tok_q;
	logic   in_list;
	logic   is_left;
	logic   take;
	logic   give;
	logic   wr_sel;

	assign in_list = cnt_t'(idx) < cmd.length;
	assign hole    = mark_q || !in_list;
	assign live    = !hole;
	assign is_left = idx[0] == cmd.phase;
	assign take    = cmd.swap && is_left && hole && right_live;
	assign give    = cmd.swap && !is_left && left_hole && live;
	assign wr_sel  = cmd.write && (cnt_t'(idx) == cmd.length);
	assign hit     = cmd.search && tok_q && live && (value_q == cmd.data);

	assign entry = '{value: value_q, mark: mark_q};
	assign carry = carry_q;
	assign tok   = tok_q;

	always_ff @(posedge clk) begin
		if (wr_sel) begin
			value_q <= cmd.data;
		end else if (take) begin
			value_q <= right_entry.value;
		end
		if (cmd.load) begin
			carry_q <= '{value: value_q, mark: mark_q};
		end else if (cmd.shift) begin
			carry_q <= right_carry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= 1'b0;
			tok_q  <= 1'b0;
		end else begin
			if (cmd.clear || wr_sel || take) begin
				mark_q <= 1'b0;
			end else if (give || hit) begin
				mark_q <= 1'b1;
			end
			tok_q <= (cmd.seed || cmd.search) ? left_tok : 1'b0;
		end
	end

endmodule

// ===== rtl/ldlt_ctrl.sv =====
// Controller of the lazy deletion list table: takes requests, sequences the
// cell row through search, read and compaction, keeps counts, holds the result.
// Depends on ldlt_pkg and ldlt_if.
module ldlt_ctrl import ldlt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ldlt_req_if.sink    req,
	ldlt_rsp_if.source  rsp,
	output cell_cmd_t   cmd,
	input  chain_stat_t stat
);

	state_t  state_q, state_d;
	idx_t    cnt_q, cnt_d;
	idx_t    pos_q, pos_d;
	cnt_t    length_q, length_d;
	cnt_t    live_q, live_d;
	cnt_t    del_q, del_d;
	value_t  key_q, key_d;
	logic    phase_q, phase_d;
	result_t res_q, res_d;
	logic    out_valid_q, out_valid_d;
	result_t out_q, out_d;
	cnt_t    out_live_q, out_live_d;
	cnt_t    out_del_q, out_del_d;
	logic    accept;

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.read_value    = out_q.read_value;
	assign rsp.read_marked   = out_q.read_marked;
	assign rsp.compacted     = out_q.compacted;
	assign rsp.live_count    = COUNT_W'(out_live_q);
	assign rsp.deleted_count = COUNT_W'(out_del_q);

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		pos_d       = pos_q;
		length_d    = length_q;
		live_d      = live_q;
		del_d       = del_q;
		key_d       = key_q;
		phase_d     = phase_q;
		res_d       = res_q;
		out_d       = out_q;
		out_live_d  = out_live_q;
		out_del_d   = out_del_q;
		out_valid_d = out_valid_q && !rsp.ready;
		cmd         = '0;
		cmd.data    = key_q;
		cmd.length  = length_q;
		cmd.phase   = phase_q;
		req.ready   = state_q == S_IDLE;
		accept      = req.valid && req.ready;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_d   = '{status: ST_OK, read_value: '0, read_marked: 1'b0,
						compacted: 1'b0};
					key_d   = ext_value(req.value);
					state_d = S_RESULT;
					case (op_t'(req.operation))
						OP_APPEND: begin
							if (length_q >= cnt_t'(CAPACITY)) begin
								res_d.status = ST_FULL;
							end else begin
								cmd.write = 1'b1;
								cmd.data  = ext_value(req.value);
								length_d  = length_q + cnt_t'(1);
								live_d    = live_q + cnt_t'(1);
							end
						end
						OP_REMOVE: begin
							if (length_q == '0) begin
								res_d.status = ST_EMPTY;
							end else begin
								cmd.seed = 1'b1;
								cnt_d    = '0;
								state_d  = S_SEARCH;
							end
						end
						OP_READ: begin
							if (pos_beyond(req.position, length_q)) begin
								res_d.status = ST_BEYOND;
							end else begin
								cmd.load = 1'b1;
								pos_d    = IDX_W'(req.position);
								cnt_d    = '0;
								state_d  = S_READ;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_SEARCH: begin
				cmd.search = 1'b1;
				if (stat.hit) begin
					del_d = del_q + cnt_t'(1);
					live_d = live_q - cnt_t'(1);
					if (del_d >= live_d) begin
						res_d.compacted = 1'b1;
						cnt_d   = '0;
						phase_d = 1'b0;
						state_d = S_COMPACT;
					end else begin
						state_d = S_RESULT;
					end
				end else if (cnt_t'(cnt_q) + cnt_t'(1) >= length_q) begin
					res_d.status = ST_NOT_FOUND;
					state_d = S_RESULT;
				end else begin
					cnt_d = cnt_q + idx_t'(1);
				end
			end
			S_READ: begin
				if (cnt_q == pos_q) begin
					res_d.read_value  = read_field(stat.head_value);
					res_d.read_marked = stat.head_mark;
					state_d = S_RESULT;
				end else begin
					cmd.shift = 1'b1;
					cnt_d = cnt_q + idx_t'(1);
				end
			end
			S_COMPACT: begin
				cmd.swap = 1'b1;
				phase_d  = !phase_q;
				if (cnt_q == idx_t'(CAPACITY - 1)) begin
					length_d = live_q;
					del_d    = '0;
					state_d  = S_RESULT;
				end else begin
					cnt_d = cnt_q + idx_t'(1);
				end
			end
			S_RESULT: begin
				cmd.clear = res_q.compacted;
				if (!out_valid_q || rsp.ready) begin
					out_valid_d = 1'b1;
					out_d       = res_q;
					out_live_d  = live_q;
					out_del_d   = del_q;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			length_q    <= '0;
			live_q      <= '0;
			del_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			length_q    <= length_d;
			live_q      <= live_d;
			del_q       <= del_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cnt_q      <= cnt_d;
		pos_q      <= pos_d;
		key_q      <= key_d;
		phase_q    <= phase_d;
		res_q      <= res_d;
		out_q      <= out_d;
		out_live_q <= out_live_d;
		out_del_q  <= out_del_d;
	end

`ifndef NO_ASSERTIONS
	a_counts_sum: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(live_q) + SUM_W'(del_q) == SUM_W'(length_q))
		else $error("live and deleted counts do not add up to the list length");
	a_length_cap: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= cnt_t'(CAPACITY))
		else $error("list length exceeds the table capacity");
	a_idle_compacted: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> (del_q == '0 || del_q < live_q))
		else $error("idle with a deleted count that calls for compaction");
	a_hit_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		stat.hit |-> state_q == S_SEARCH)
		else $error("cell row reports a match outside a search");
`endif

endmodule

// ===== tb/lazy_delete_list_table_test.sv =====
// Self-checking testbench for lazy_delete_list_table: drives append, remove, read and
// no-op transactions under random idling and checks every response against a predictor.
// Depends on ldlt_pkg, ldlt_req_if, ldlt_rsp_if and the lazy_delete_list_table RTL.
module lazy_delete_list_table_test;
	import ldlt_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;
	localparam int MAX_REPORTS   = 10;
	localparam logic signed [DATA_W-1:0] MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct {
		status_t                  status;
		logic signed [DATA_W-1:0] read_value;
		logic                     read_marked;
		logic [COUNT_W-1:0]       live_count;
		logic [COUNT_W-1:0]       deleted_count;
		logic                     compacted;
	} outcome_t;

	class list_table_scoreboard;
		logic signed [DATA_W-1:0] vals[CAPACITY];
		bit                       marks[CAPACITY];
		int unsigned              len;
		int unsigned              live;
		int unsigned              dead;
		outcome_t                 pending[$];
		int                       mismatches;

		function new();
			len        = 0;
			live       = 0;
			dead       = 0;
			mismatches = 0;
			foreach (marks[i]) begin
				marks[i] = 1'b0;
				vals[i]  = '0;
			end
		endfunction

		function void note_request(input op_t op, input logic signed [DATA_W-1:0] val,
			input logic [POS_W-1:0] pos);
			outcome_t    exp;
			bit          hit;
			int unsigned kept;
			exp.status        = ST_OK;
			exp.read_value    = '0;
			exp.read_marked   = 1'b0;
			exp.compacted     = 1'b0;
			hit               = 1'b0;
			case (op)
				OP_APPEND: begin
					if (len >= CAPACITY) begin
						exp.status = ST_FULL;
					end else begin
						vals[len]  = val;
						marks[len] = 1'b0;
						len++;
						live++;
					end
				end
				OP_REMOVE: begin
					if (len == 0) begin
						exp.status = ST_EMPTY;
					end else begin
						for (int i = 0; i < len && !hit; i++) begin
							if (!marks[i] && vals[i] == val) begin
								marks[i] = 1'b1;
								hit      = 1'b1;
							end
						end
						if (hit) begin
							dead++;
							if (live > 0) live--;
						end else begin
							exp.status = ST_NOT_FOUND;
						end
					end
				end
				OP_READ: begin
					if (pos >= len) begin
						exp.status = ST_BEYOND;
					end else begin
						exp.read_value  = vals[pos];
						exp.read_marked = marks[pos];
					end
				end
				default: ;
			endcase
			// The read fields above reflect the table before any compaction.
			if (dead != 0 && dead >= live) begin
				kept = 0;
				for (int i = 0; i < len; i++) begin
					if (!marks[i]) begin
						vals[kept] = vals[i];
						kept++;
					end
				end
				foreach (marks[i]) marks[i] = 1'b0;
				len           = kept;
				live          = kept;
				dead          = 0;
				exp.compacted = 1'b1;
			end
			exp.live_count    = COUNT_W'(live);
			exp.deleted_count = COUNT_W'(dead);
			pending.push_back(exp);
		endfunction

		function void check_response(input outcome_t got);
			outcome_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: response with no transaction outstanding: status %0d",
						$realtime, got.status);
				return;
			end
			exp = pending.pop_front();
			if (got.status !== exp.status || got.read_value !== exp.read_value ||
				got.read_marked !== exp.read_marked || got.live_count !== exp.live_count ||
				got.deleted_count !== exp.deleted_count || got.compacted !== exp.compacted) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: expected status %0d value %0d marked %0d live %0d deleted %0d compacted %0d",
						$realtime, exp.status, exp.read_value, exp.read_marked,
						exp.live_count, exp.deleted_count, exp.compacted);
					$display("%0t: actual   status %0d value %0d marked %0d live %0d deleted %0d compacted %0d",
						$realtime, got.status, got.read_value, got.read_marked,
						got.live_count, got.deleted_count, got.compacted);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   give_idle_pct;
	int   take_idle_pct;
	int   sent_items;

	list_table_scoreboard sb = new();

	ldlt_req_if req();
	ldlt_rsp_if rsp();

	lazy_delete_list_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp.ready <= ($urandom_range(99) >= take_idle_pct);
		end
	end

	initial begin
		outcome_t got;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready) begin
				got.status        = rsp.status;
				got.read_value    = rsp.read_value;
				got.read_marked   = rsp.read_marked;
				got.live_count    = rsp.live_count;
				got.deleted_count = rsp.deleted_count;
				got.compacted     = rsp.compacted;
				sb.check_response(got);
			end
		end
	end

	task automatic send_item(input op_t op, input logic signed [DATA_W-1:0] val,
		input logic [POS_W-1:0] pos);
		while ($urandom_range(99) < give_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid     <= 1'b1;
		req.operation <= op;
		req.value     <= val;
		req.position  <= pos;
		do @(posedge clk); while (!req.ready);
		sb.note_request(op, val, pos);
		sent_items++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return MOST_NEG;
			1: return MOST_POS;
			2, 3, 4: return DATA_W'(int'($urandom_range(6)) - 3);
			5, 6: return (sb.len > 0) ? sb.vals[$urandom_range(sb.len - 1)] : $urandom;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		if (sb.len > 0 && $urandom_range(9) < 7)
			return POS_W'($urandom_range(sb.len - 1));
		return POS_W'($urandom_range(CAPACITY - 1));
	endfunction

	task automatic run_random(input int target);
		int pick;
		while (sent_items < target) begin
			pick = $urandom_range(29);
			if (pick == 0) begin
				while (sb.len < CAPACITY) send_item(OP_APPEND, pick_value(), pick_position());
				repeat (2) send_item(OP_APPEND, pick_value(), pick_position());
			end else if (pick <= 2) begin
				repeat ($urandom_range(12, 4)) begin
					if (sb.len > 0)
						send_item(OP_REMOVE, sb.vals[$urandom_range(sb.len - 1)], pick_position());
					else
						send_item(OP_REMOVE, pick_value(), pick_position());
				end
			end else begin
				pick = $urandom_range(99);
				if (pick < 45)
					send_item(OP_APPEND, pick_value(), POS_W'($urandom));
				else if (pick < 80)
					send_item(OP_REMOVE, pick_value(), POS_W'($urandom));
				else if (pick < 95)
					send_item(OP_READ, $urandom, pick_position());
				else
					send_item(OP_NOP, $urandom, POS_W'($urandom));
			end
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		req.valid     = 1'b0;
		req.operation = '0;
		req.value     = '0;
		req.position  = '0;
		give_idle_pct = 6;
		take_idle_pct = 47;
		sent_items    = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_item(OP_REMOVE, '0, '0);
		send_item(OP_READ, '0, '0);
		send_item(OP_READ, '0, POS_W'(CAPACITY - 1));
		send_item(OP_NOP, -1, '1);
		send_item(OP_APPEND, MOST_NEG, '0);
		send_item(OP_APPEND, MOST_POS, '1);
		send_item(OP_APPEND, -1, '0);
		send_item(OP_APPEND, 5, '0);
		send_item(OP_APPEND, 5, '0);
		send_item(OP_REMOVE, 5, '0);
		send_item(OP_READ, '0, 3);
		send_item(OP_REMOVE, 5, '0);
		send_item(OP_REMOVE, 5, '0);
		send_item(OP_READ, '0, 4);
		send_item(OP_REMOVE, 77, '0);
		send_item(OP_REMOVE, MOST_NEG, '0);
		send_item(OP_READ, '0, 0);
		send_item(OP_READ, '0, 1);
		send_item(OP_READ, '0, 2);
		send_item(OP_REMOVE, MOST_POS, '0);
		send_item(OP_REMOVE, -1, '0);
		send_item(OP_APPEND, '0, '0);

		run_random(sent_items + 220);
		wait_drained();
		give_idle_pct = 47;
		take_idle_pct = 6;
		run_random(sent_items + 220);
		wait_drained();
		give_idle_pct = 0;
		take_idle_pct = 0;
		run_random(sent_items + 210);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ldlt_pkg.sv
rtl/ldlt_if.sv
rtl/ldlt_cell.sv
rtl/ldlt_ctrl.sv
rtl/lazy_delete_list_table.sv
tb/lazy_delete_list_table_test.sv
